@@ src/scpa_pkg.sv @@
`default_nettype none

package scpa_pkg;

	// Default disparity range
	localparam int DISPARITIES_DEF = 64;

	// Fixed field widths
	localparam int CODE_W    = 8;
	localparam int MATCH_W   = 4;
	localparam int COST_W    = 9;
	localparam int DISP_W    = 6;
	localparam int PEN_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Headroom for cost + candidate - minimum
	localparam int SUM_W = COST_W + 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMALL_PENALTY = 2'd0,
		REG_LARGE_PENALTY = 2'd1
	} reg_idx_t;

	localparam logic [PEN_W-1:0] SMALL_PENALTY_RST = 8'd10;
	localparam logic [PEN_W-1:0] LARGE_PENALTY_RST = 8'd120;

	// Start value of the running minimum search
	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Pixel sequencer
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PRIME = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	// Previous path costs at d-1, d and d+1
	typedef struct packed {
		logic [COST_W-1:0] lo;
		logic [COST_W-1:0] mid;
		logic [COST_W-1:0] hi;
	} window_t;

	// Per-disparity control for the cost unit
	typedef struct packed {
		logic first;
		logic has_lo;
		logic has_hi;
		logic is_best;
	} cost_ctl_t;

endpackage

`default_nettype wire

@@ src/scpa_ram.sv @@
`default_nettype none

module scpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/scpa_cost.sv @@
`default_nettype none

module scpa_cost (
	input  wire logic [scpa_pkg::CODE_W-1:0]  left_code,
	input  wire logic [scpa_pkg::CODE_W-1:0]  right_code,
	input  wire scpa_pkg::window_t            win,
	input  wire scpa_pkg::cost_ctl_t          ctl,
	input  wire logic [scpa_pkg::PEN_W-1:0]   small_penalty,
	input  wire logic [scpa_pkg::COST_W:0]    min_p2,
	input  wire logic [scpa_pkg::COST_W:0]    smin_p2,
	input  wire logic [scpa_pkg::COST_W-1:0]  prev_min,
	output logic      [scpa_pkg::MATCH_W-1:0] match_cost,
	output logic      [scpa_pkg::COST_W-1:0]  path_cost
);

	import scpa_pkg::*;

	logic [CODE_W-1:0]  diff;
	logic [MATCH_W-1:0] ones;
	logic [COST_W:0]    mid_ext;
	logic [COST_W:0]    lo_p1;
	logic [COST_W:0]    hi_p1;
	logic [COST_W:0]    cand_a;
	logic [COST_W:0]    cand_b;
	logic [COST_W:0]    jump;
	logic [COST_W:0]    best;
	logic [SUM_W-1:0]   sum;

	// Hamming distance of the two census codes
	assign diff = left_code ^ right_code;

	always_comb begin
		ones = '0;
		for (int i = 0; i < CODE_W; i++) begin
			ones = ones + MATCH_W'(diff[i]);
		end
	end

	// Neighbour candidates with the small penalty
	assign mid_ext = (COST_W+1)'(win.mid);
	assign lo_p1   = (COST_W+1)'(win.lo) + (COST_W+1)'(small_penalty);
	assign hi_p1   = (COST_W+1)'(win.hi) + (COST_W+1)'(small_penalty);

	// Minimum over the four transitions
	assign cand_a = (ctl.has_lo && (lo_p1 < mid_ext)) ? lo_p1 : mid_ext;
	assign cand_b = (ctl.has_hi && (hi_p1 < cand_a)) ? hi_p1 : cand_a;
	assign jump   = ctl.is_best ? smin_p2 : min_p2;
	assign best   = (jump < cand_b) ? jump : cand_b;

	// Normalise by the previous minimum; wraps to the field width
	assign sum = SUM_W'(ones) + SUM_W'(best) - SUM_W'(prev_min);

	assign match_cost = ones;
	assign path_cost  = ctl.first ? COST_W'(ones) : sum[COST_W-1:0];

endmodule

`default_nettype wire

@@ src/sgm_census_path_aggregator.sv @@
// First result: an accepted pixel passes the priming state, then the run state's output register.
// Throughput: one result a cycle while the output is not stalled; no new pixel is taken until the
//   last result, and the idle and priming states prime the path-cost memory's registered read.
// Reset: asynchronous, active low; penalties go to 10 and 120, the previous minima to zero,
//   and the right-code history reads as empty. The path-cost memory is not cleared.
`default_nettype none

module sgm_census_path_aggregator #(
	parameter int DISPARITIES = scpa_pkg::DISPARITIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [scpa_pkg::CODE_W-1:0]       left_code,
	input  wire logic [scpa_pkg::CODE_W-1:0]       right_code,
	input  wire logic                              row_start,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [scpa_pkg::DISP_W-1:0]       disparity,
	output logic      [scpa_pkg::MATCH_W-1:0]      match_cost,
	output logic      [scpa_pkg::COST_W-1:0]       path_cost,
	output logic                                   last_of_pixel,
	input  wire logic                              cfg_wr_en,
	input  wire logic [scpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [scpa_pkg::PEN_W-1:0]        cfg_data
);

	import scpa_pkg::*;

	localparam int              D_W      = $clog2(DISPARITIES);
	localparam int              CNT_W    = $clog2(DISPARITIES + 1);
	localparam logic [D_W:0]    D_EXT    = (D_W+1)'(DISPARITIES);
	localparam logic [D_W-1:0]  D_LAST   = D_W'(DISPARITIES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DISPARITIES);

	state_t             state_q;
	logic [PEN_W-1:0]   small_pen_q;
	logic [PEN_W-1:0]   large_pen_q;

	// Current pixel
	logic [CODE_W-1:0]  left_q;
	logic [CODE_W-1:0]  right_q;
	logic               first_q;
	logic [D_W-1:0]     d_q;

	// Right-code history bookkeeping
	logic [D_W-1:0]     wp_q;
	logic [CNT_W-1:0]   fill_q;

	// Previous pixel summary
	logic [COST_W-1:0]  prev_min_q;
	logic [COST_W-1:0]  prev_smin_q;
	logic [DISP_W-1:0]  prev_best_q;
	logic [COST_W:0]    min_p2_q;
	logic [COST_W:0]    smin_p2_q;

	// Running minimum of the current pixel
	logic [COST_W-1:0]  run_min_q;
	logic [COST_W-1:0]  run_smin_q;
	logic [D_W-1:0]     run_best_q;

	// Path-cost window
	logic [COST_W-1:0]  lo_q;
	logic [COST_W-1:0]  mid_q;

	// Output register
	logic               out_valid_q;
	logic [DISP_W-1:0]  disparity_q;
	logic [MATCH_W-1:0] match_cost_q;
	logic [COST_W-1:0]  path_cost_q;
	logic               last_q;

	logic               adv;
	logic               is_last;
	logic [D_W:0]       d_inc;
	logic [D_W:0]       d_nxt;
	logic [D_W:0]       path_ahead;
	logic [D_W:0]       slot_sum;
	logic [D_W:0]       slot_wrap;
	logic [D_W-1:0]     path_raddr;
	logic [D_W-1:0]     right_raddr;
	logic [COST_W-1:0]  path_rdata;
	logic [CODE_W-1:0]  right_rdata;
	logic [CNT_W-1:0]   fill_eff;
	logic [CNT_W-1:0]   fill_next;
	logic               code_ok;
	logic [CODE_W-1:0]  rcode;
	window_t            win;
	cost_ctl_t          ctl;
	logic [MATCH_W-1:0] match_c;
	logic [COST_W-1:0]  path_c;
	logic [COST_W-1:0]  new_min;
	logic [COST_W-1:0]  new_smin;
	logic [D_W-1:0]     new_best;

	// Step control
	assign adv     = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign is_last = (d_q == D_LAST);
	assign d_inc   = (D_W+1)'(d_q) + (D_W+1)'(1);
	assign d_nxt   = adv ? d_inc : (D_W+1)'(d_q);

	// Read one disparity ahead; held while the output is stalled
	assign path_ahead = d_nxt + (D_W+1)'(1);
	assign path_raddr = ((state_q == ST_IDLE) || (path_ahead >= D_EXT)) ? '0
	                    : path_ahead[D_W-1:0];

	// Circular history: the code k columns back sits k slots behind the write pointer
	assign slot_sum    = (D_W+1)'(wp_q) + D_EXT - d_nxt;
	assign slot_wrap   = slot_sum - D_EXT;
	assign right_raddr = (slot_sum >= D_EXT) ? slot_wrap[D_W-1:0] : slot_sum[D_W-1:0];

	scpa_ram #(
		.WIDTH (COST_W),
		.DEPTH (DISPARITIES)
	) u_path_ram (
		.clk   (clk),
		.we    (adv),
		.waddr (d_q),
		.wdata (path_c),
		.raddr (path_raddr),
		.rdata (path_rdata)
	);

	scpa_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DISPARITIES)
	) u_right_ram (
		.clk   (clk),
		.we    (adv && is_last),
		.waddr (wp_q),
		.wdata (right_q),
		.raddr (right_raddr),
		.rdata (right_rdata)
	);

	// Codes from before the row start read as zero
	assign fill_eff  = first_q ? '0 : fill_q;
	assign fill_next = (fill_eff == CNT_FULL) ? fill_eff : fill_eff + CNT_W'(1);
	assign code_ok   = (CNT_W'(d_q) <= fill_eff);
	assign rcode     = (d_q == '0) ? right_q : (code_ok ? right_rdata : '0);

	assign win.lo  = lo_q;
	assign win.mid = mid_q;
	assign win.hi  = path_rdata;

	assign ctl.first   = first_q;
	assign ctl.has_lo  = (d_q != '0);
	assign ctl.has_hi  = !is_last;
	assign ctl.is_best = (DISP_W'(d_q) == prev_best_q);

	scpa_cost u_cost (
		.left_code     (left_q),
		.right_code    (rcode),
		.win           (win),
		.ctl           (ctl),
		.small_penalty (small_pen_q),
		.min_p2        (min_p2_q),
		.smin_p2       (smin_p2_q),
		.prev_min      (prev_min_q),
		.match_cost    (match_c),
		.path_cost     (path_c)
	);

	// Running minimum, lowest disparity wins ties
	always_comb begin
		new_min  = run_min_q;
		new_smin = run_smin_q;
		new_best = run_best_q;
		if (path_c < run_min_q) begin
			new_smin = run_min_q;
			new_min  = path_c;
			new_best = d_q;
		end else if (path_c < run_smin_q) begin
			new_smin = path_c;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_pen_q <= SMALL_PENALTY_RST;
			large_pen_q <= LARGE_PENALTY_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_SMALL_PENALTY: small_pen_q <= cfg_data;
				REG_LARGE_PENALTY: large_pen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and state kept across pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			d_q         <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			prev_min_q  <= '0;
			prev_smin_q <= '0;
			prev_best_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						d_q     <= '0;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (adv) begin
						d_q <= d_inc[D_W-1:0];
						if (is_last) begin
							state_q     <= ST_IDLE;
							prev_min_q  <= new_min;
							prev_smin_q <= new_smin;
							prev_best_q <= DISP_W'(new_best);
							fill_q      <= fill_next;
							wp_q        <= (wp_q == D_LAST) ? '0 : wp_q + D_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pixel payload, window and running minimum
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			left_q  <= left_code;
			right_q <= right_code;
			first_q <= row_start;
		end
		if (state_q == ST_PRIME) begin
			mid_q      <= path_rdata;
			min_p2_q   <= (COST_W+1)'(prev_min_q) + (COST_W+1)'(large_pen_q);
			smin_p2_q  <= (COST_W+1)'(prev_smin_q) + (COST_W+1)'(large_pen_q);
			run_min_q  <= COST_MAX;
			run_smin_q <= COST_MAX;
			run_best_q <= '0;
		end
		if (adv) begin
			lo_q       <= mid_q;
			mid_q      <= path_rdata;
			run_min_q  <= new_min;
			run_smin_q <= new_smin;
			run_best_q <= new_best;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disparity_q  <= DISP_W'(d_q);
			match_cost_q <= match_c;
			path_cost_q  <= path_c;
			last_q       <= is_last;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign disparity     = disparity_q;
	assign match_cost    = match_cost_q;
	assign path_cost     = path_cost_q;
	assign last_of_pixel = last_q;

endmodule

`default_nettype wire

@@ src/scpa_checker.sv @@
`default_nettype none

module scpa_checker #(
	parameter int DISPARITIES = scpa_pkg::DISPARITIES_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [scpa_pkg::CODE_W-1:0]       left_code,
	input wire logic [scpa_pkg::CODE_W-1:0]       right_code,
	input wire logic                              row_start,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic [scpa_pkg::DISP_W-1:0]       disparity,
	input wire logic [scpa_pkg::MATCH_W-1:0]      match_cost,
	input wire logic [scpa_pkg::COST_W-1:0]       path_cost,
	input wire logic                              last_of_pixel,
	input wire logic                              cfg_wr_en,
	input wire logic [scpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input wire logic [scpa_pkg::PEN_W-1:0]        cfg_data
);

	import scpa_pkg::*;

	localparam logic [DISP_W-1:0] D_LAST = DISP_W'(DISPARITIES - 1);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(disparity) && $stable(path_cost)
		&& $stable(match_cost) && $stable(last_of_pixel))
		else $error("stalled result changed");

	// End-of-pixel flag marks the top disparity, match cost stays in range
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_pixel == (disparity == D_LAST)) && (match_cost <= 4'd8))
		else $error("bad end-of-pixel flag or match cost");

	// Disparities of a pixel come back to back, in order
	a_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_pixel |=>
		out_valid && (disparity == $past(disparity) + DISP_W'(1)))
		else $error("disparity sequence broken");

	// No new pixel taken while one is still being emitted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_pixel |-> in_stall)
		else $error("input open during a pixel");

endmodule

bind sgm_census_path_aggregator scpa_checker #(.DISPARITIES(DISPARITIES)) u_scpa_checker (.*);

`default_nettype wire
